// ===== hw/rtl/wave_equation_stencil_update_assert.svh =====
// Assertion macros for the wave stencil update block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef WAVE_EQUATION_STENCIL_UPDATE_ASSERT_SVH
`define WAVE_EQUATION_STENCIL_UPDATE_ASSERT_SVH

// same-cycle implication
`define WES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wes_pkg.sv =====
// Shared types and constants of the wave stencil update block.
// No dependencies.
`default_nettype none
package wes_pkg;
  localparam int MAX_COLS_DEF = 1024;
  localparam int SPEED_FRAC = 16;
  localparam int COEF_FRAC = 24;

  localparam logic [1:0] REG_GRID_COLS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [1:0] REG_COEF_X = 2'd2;
  localparam logic [1:0] REG_COEF_Y = 2'd3;

  // sequencer steps
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_R0 = 4'd1;
  localparam logic [3:0] ST_R1 = 4'd2;
  localparam logic [3:0] ST_R2 = 4'd3;
  localparam logic [3:0] ST_R3 = 4'd4;
  localparam logic [3:0] ST_R4 = 4'd5;
  localparam logic [3:0] ST_LB = 4'd6;
  localparam logic [3:0] ST_MUL = 4'd7;
  localparam logic [3:0] ST_ACC = 4'd8;
  localparam logic [3:0] ST_MUL2 = 4'd9;
  localparam logic [3:0] ST_LAP = 4'd10;
  localparam logic [3:0] ST_FIN = 4'd11;

  typedef struct packed {
    logic signed [31:0] field_now;
    logic [15:0] speed_sq;
    logic signed [31:0] field_old;
    logic signed [31:0] inject;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] field_new;
    logic [30:0] abs_max;
    logic frame_end;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic [3:0] step;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic fin_ok;
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/wes_ctrl.sv =====
// Sequencer of the wave stencil update block.
// Depends on wes_pkg.
`default_nettype none
module wes_ctrl import wes_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output cmd_t      cmd,
  input  stat_t     stat
);
  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_R0;
      ST_R0: state_nxt = ST_R1;
      ST_R1: state_nxt = ST_R2;
      ST_R2: state_nxt = ST_R3;
      ST_R3: state_nxt = ST_R4;
      ST_R4: state_nxt = ST_LB;
      ST_LB: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_LAP;
      ST_LAP: state_nxt = ST_FIN;
      ST_FIN: if (stat.fin_ok) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign cmd.load = (state_r == ST_IDLE) && in_valid;
  assign cmd.step = state_r;
  assign cmd.done = (state_r == ST_FIN) && stat.fin_ok;
endmodule
`default_nettype wire

// ===== hw/rtl/wes_dpath.sv =====
// Datapath: line buffers, window, stencil arithmetic, output register.
// Depends on wes_pkg.
`default_nettype none
module wes_dpath import wes_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata,
  input  in_item_t         in_data,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);
  localparam int DEPTH = 2 * MAX_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_COLS);
  localparam int GW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [10:0] grid_cols_r;
  logic [15:0] grid_rows_r;
  logic [23:0] coef_x_r, coef_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= 11'd1024;
      grid_rows_r <= 16'd1024;
      coef_x_r <= '0;
      coef_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_COLS: grid_cols_r <= cfg_wdata[10:0];
        REG_GRID_ROWS: grid_rows_r <= cfg_wdata[15:0];
        REG_COEF_X: coef_x_r <= cfg_wdata;
        REG_COEF_Y: coef_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [GW-1:0] gc, cols, cols_m1, c_ext;
  logic [15:0] rows, rows_m1;
  logic [CW-1:0] c_r;
  logic [15:0] r_r;
  logic interior, last_pt;

  always_comb begin
    gc = GW'(grid_cols_r);
    if (gc < GW'(3)) cols = GW'(3);
    else if (gc > GW'(MAX_COLS)) cols = GW'(MAX_COLS);
    else cols = gc;
    cols_m1 = cols - GW'(1);
    rows = (grid_rows_r < 16'd3) ? 16'd3 : grid_rows_r;
    rows_m1 = rows - 16'd1;
    c_ext = GW'(c_r);
    interior = (r_r >= 16'd2) && (c_ext >= GW'(2)) && (r_r <= rows_m1) && (c_ext <= cols_m1);
    last_pt = (r_r == rows_m1) && (c_ext == cols_m1);
  end

  // addresses
  logic [AW-1:0] p_base, q_base, pc, qc, f_addr, s_addr;
  always_comb begin
    p_base = r_r[0] ? AW'(MAX_COLS) : '0;
    q_base = r_r[0] ? '0 : AW'(MAX_COLS);
    pc = p_base + AW'(c_r);
    qc = q_base + AW'(c_r);
    case (cmd.step)
      ST_R0: f_addr = pc;
      ST_R1: f_addr = qc;
      ST_R2: f_addr = qc - AW'(1);
      ST_R3: f_addr = qc - AW'(2);
      default: f_addr = pc - AW'(1);
    endcase
    case (cmd.step)
      ST_R0: s_addr = pc;
      ST_R1: s_addr = qc - AW'(1);
      default: s_addr = qc - AW'(2);
    endcase
  end

  in_item_t item_r;
  always_ff @(posedge clk) if (cmd.load) item_r <= in_data;

  // line buffers; write at R0 returns the old entry
  logic [31:0] field_mem [DEPTH];
  logic [15:0] speed_mem [DEPTH];
  logic [31:0] f_rd;
  logic [15:0] s_rd;

  always_ff @(posedge clk) begin
    f_rd <= field_mem[f_addr];
    if (cmd.step == ST_R0) field_mem[pc] <= item_r.field_now;
  end
  always_ff @(posedge clk) begin
    s_rd <= speed_mem[s_addr];
    if (cmd.step == ST_R0) speed_mem[pc] <= item_r.speed_sq;
  end

  // row r-2 window
  logic [31:0] win_f_r [3];
  logic [15:0] win_s_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_f_r[i] <= '0;
        win_s_r[i] <= '0;
      end
    end else if (cmd.step == ST_R1) begin
      win_f_r[2] <= win_f_r[1];
      win_f_r[1] <= win_f_r[0];
      win_f_r[0] <= f_rd;
      win_s_r[2] <= win_s_r[1];
      win_s_r[1] <= win_s_r[0];
      win_s_r[0] <= s_rd;
    end
  end

  logic signed [31:0] rr_r, cc_r, ll_r, bb_r;
  logic [15:0] sc_r, sl_r;
  always_ff @(posedge clk) begin
    if (cmd.step == ST_R2) begin
      rr_r <= f_rd;
      sc_r <= s_rd;
    end
    if (cmd.step == ST_R3) begin
      cc_r <= f_rd;
      sl_r <= s_rd;
    end
    if (cmd.step == ST_R4) ll_r <= f_rd;
    if (cmd.step == ST_LB) bb_r <= f_rd;
  end

  // stencil products
  logic signed [32:0] d_r, d_l, d_b, d_t;
  logic signed [17:0] w_a0, w_a1, w_b0, w_b1;
  logic signed [50:0] pa0_r, pa1_r, pb0_r, pb1_r;
  always_comb begin
    d_r = 33'(rr_r) - 33'(cc_r);
    d_l = 33'(ll_r) - 33'(cc_r);
    d_b = 33'(bb_r) - 33'(cc_r);
    d_t = 33'($signed(win_f_r[1])) - 33'(cc_r);
    w_a0 = $signed({2'b00, win_s_r[1]} + {2'b00, sc_r});
    w_a1 = $signed({2'b00, win_s_r[2]} + {2'b00, sl_r});
    w_b0 = $signed({2'b00, sl_r} + {2'b00, sc_r});
    w_b1 = $signed({2'b00, win_s_r[2]} + {2'b00, win_s_r[1]});
  end
  always_ff @(posedge clk) begin
    if (cmd.step == ST_MUL) begin
      pa0_r <= 51'(d_r * w_a0);
      pa1_r <= 51'(d_l * w_a1);
      pb0_r <= 51'(d_b * w_b0);
      pb1_r <= 51'(d_t * w_b1);
    end
  end

  // round half up by 2^16
  logic signed [51:0] a_sum, b_sum;
  logic signed [35:0] ar_r, br_r;
  always_comb begin
    a_sum = 52'(pa0_r) + 52'(pa1_r) + 52'sd32768;
    b_sum = 52'(pb0_r) + 52'(pb1_r) + 52'sd32768;
  end
  always_ff @(posedge clk) begin
    if (cmd.step == ST_ACC) begin
      ar_r <= 36'(a_sum >>> SPEED_FRAC);
      br_r <= 36'(b_sum >>> SPEED_FRAC);
    end
  end

  logic signed [60:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (cmd.step == ST_MUL2) begin
      px_r <= 61'($signed({1'b0, coef_x_r}) * ar_r);
      py_r <= 61'($signed({1'b0, coef_y_r}) * br_r);
    end
  end

  logic signed [61:0] l_sum;
  logic signed [37:0] lap_r;
  assign l_sum = 62'(px_r) + 62'(py_r) + 62'sd8388608;
  always_ff @(posedge clk) if (cmd.step == ST_LAP) lap_r <= 38'(l_sum >>> COEF_FRAC);

  // final sum, saturation, magnitude
  logic signed [40:0] v;
  logic signed [31:0] v_sat;
  logic [30:0] mag, max_upd, run_max_r;
  always_comb begin
    v = (41'(cc_r) <<< 1) - 41'(item_r.field_old) + 41'(lap_r) + 41'(item_r.inject);
    if (v > 41'sd2147483647) v_sat = 32'sh7fffffff;
    else if (v < -41'sd2147483648) v_sat = 32'sh80000000;
    else v_sat = 32'(v);
    if (v_sat == 32'sh80000000) mag = 31'h7fffffff;
    else if (v_sat[31]) mag = 31'(-v_sat);
    else mag = v_sat[30:0];
    max_upd = (mag > run_max_r) ? mag : run_max_r;
  end

  logic out_valid_r;
  out_item_t out_data_r;
  assign stat.fin_ok = !interior || !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r <= '0;
      r_r <= '0;
      c_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.done && interior) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load && r_r == 16'd0 && c_r == '0) run_max_r <= '0;
      if (cmd.done) begin
        if (interior) begin
          run_max_r <= max_upd;
        end
        if (c_ext >= cols_m1) begin
          c_r <= '0;
          r_r <= (r_r >= rows_m1) ? 16'd0 : r_r + 16'd1;
        end else begin
          c_r <= c_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done && interior) begin
      out_data_r.field_new <= v_sat;
      out_data_r.abs_max <= max_upd;
      out_data_r.frame_end <= last_pt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
endmodule
`default_nettype wire

// ===== hw/rtl/wave_equation_stencil_update.sv =====
// Streaming five-point stencil update for the 2-D wave equation. Grid points
// enter in raster order; each request carries the current field, speed squared,
// the older field of the point one row up and one column left, and a source
// term. For every interior point one result leaves with the saturated new
// value, the running maximum magnitude of the frame and a frame end flag.
// A request keeps the sequencer busy through steps R0 to R4, LB, MUL, ACC,
// MUL2, LAP and FIN, so a new request is accepted only once the last one has
// finished. The two line buffers have one read port each, so the five field
// reads are issued one per cycle, followed by two registered multiply stages
// with rounding. A result waiting in the output register does not hold off the
// next request; only a second finished result waits for it, held in FIN while
// the output is stalled. Line buffers have no reset.
`default_nettype none
module wave_equation_stencil_update import wes_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata,
  // grid point requests
  input  wire logic        in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);
  cmd_t cmd;
  stat_t stat;

  wes_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .stat(stat)
  );

  wes_dpath #(.MAX_COLS(MAX_COLS)) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

`include "wave_equation_stencil_update_assert.svh"
  // an accepted request keeps the sequencer busy next cycle
  `WES_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not followed by busy")
  // finishing always frees the input side
  `WES_ASSERT_NEXT(a_idle_after_done, cmd.done, !in_stall, "sequencer did not return to idle")
  // a result is only posted on a finishing step
  `WES_ASSERT_NEXT(a_out_source, !out_valid && !cmd.done, !out_valid, "result without finish")
endmodule
`default_nettype wire

// ===== tb/sv/stencil_checker.sv =====
// Scoreboard for the wave stencil update block: watches the config port and both
// channels, predicts each result and compares it. Depends on wes_pkg.
`timescale 1ns / 1ps
module stencil_checker import wes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  in_item_t         in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  out_item_t        out_data,
  output int               err_count,
  output int               pending
);
  localparam int NCOLS = MAX_COLS_DEF;

  logic [31:0] field_mem [0:2*NCOLS-1];
  logic [15:0] speed_mem [0:2*NCOLS-1];
  logic [31:0] win [0:5];
  int unsigned col_pos, row_pos;
  logic [30:0] peak_mag;
  logic [10:0] cols_reg;
  logic [15:0] rows_reg;
  logic [23:0] kx, ky;
  out_item_t update_q[$];

  function automatic longint sx(logic [31:0] x);
    return longint'($signed(x));
  endfunction

  // round half up, then floor
  function automatic longint round_down(longint x, int k);
    return (x + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  task automatic predict_point(in_item_t it);
    int unsigned cols, rows, r, c, p, q;
    longint cc, ll, rr, bb, tt, s_c, s_l, s_t, s_tl, a, b, lap, v;
    logic [31:0] mag;
    out_item_t e;
    cols = cols_reg;
    if (cols < 3) cols = 3;
    if (cols > NCOLS) cols = NCOLS;
    rows = rows_reg;
    if (rows < 3) rows = 3;
    r = row_pos;
    c = col_pos;
    if (c >= NCOLS) c = NCOLS - 1;
    if (r == 0 && c == 0) peak_mag = '0;
    p = (r & 1) * NCOLS;
    q = ((r & 1) ^ 1) * NCOLS;
    win[2] = win[1];
    win[1] = win[0];
    win[0] = field_mem[p + c];
    win[5] = win[4];
    win[4] = win[3];
    win[3] = {16'd0, speed_mem[p + c]};
    field_mem[p + c] = it.field_now;
    speed_mem[p + c] = it.speed_sq;
    if (r >= 2 && c >= 2 && r <= rows - 1 && c <= cols - 1) begin
      cc = sx(field_mem[q + c - 1]);
      ll = sx(field_mem[q + c - 2]);
      rr = sx(field_mem[q + c]);
      bb = sx(field_mem[p + c - 1]);
      tt = sx(win[1]);
      s_c = speed_mem[q + c - 1];
      s_l = speed_mem[q + c - 2];
      s_t = win[4];
      s_tl = win[5];
      a = (rr - cc) * (s_t + s_c) + (ll - cc) * (s_tl + s_l);
      b = (bb - cc) * (s_l + s_c) + (tt - cc) * (s_tl + s_t);
      lap = round_down(longint'(kx) * round_down(a, SPEED_FRAC)
                       + longint'(ky) * round_down(b, SPEED_FRAC), COEF_FRAC);
      v = 2 * cc - sx(it.field_old) + lap + sx(it.inject);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (v == -64'sd2147483648) mag = 32'h7fffffff;
      else if (v < 0) mag = 32'(-v);
      else mag = 32'(v);
      if (mag[30:0] > peak_mag) peak_mag = mag[30:0];
      e.field_new = v[31:0];
      e.abs_max = peak_mag;
      e.frame_end = (r == rows - 1 && c == cols - 1);
      update_q.push_back(e);
    end
    if (c >= cols - 1) begin
      col_pos = 0;
      row_pos = (r >= rows - 1) ? 0 : ((r + 1) & 16'hffff);
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int i = 0; i < 2 * NCOLS; i++) begin
        field_mem[i] = '0;
        speed_mem[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      peak_mag = '0;
      cols_reg = 11'd1024;
      rows_reg = 16'd1024;
      kx = '0;
      ky = '0;
      update_q.delete();
      err_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_COLS: cols_reg = cfg_wdata[10:0];
          REG_GRID_ROWS: rows_reg = cfg_wdata[15:0];
          REG_COEF_X: kx = cfg_wdata;
          REG_COEF_Y: ky = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (update_q.size() == 0) begin
          $error("unexpected result: field_new %0d", out_data.field_new);
          err_count++;
        end else begin
          e = update_q.pop_front();
          if (out_data.field_new !== e.field_new) begin
            $error("field_new: expected %0d, got %0d", e.field_new, out_data.field_new);
            err_count++;
          end
          if (out_data.abs_max !== e.abs_max) begin
            $error("abs_max: expected %0d, got %0d", e.abs_max, out_data.abs_max);
            err_count++;
          end
          if (out_data.frame_end !== e.frame_end) begin
            $error("frame_end: expected %0d, got %0d", e.frame_end, out_data.frame_end);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_point(in_data);
    end
    pending = update_q.size();
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the wave stencil update testbench: clock, reset, request stimulus,
// result stall pattern and verdict. Depends on wes_pkg and stencil_checker.
`timescale 1ns / 1ps
module testbench;
  import wes_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  int err_count, pending;

  // stimulus side copy of the raster position and effective geometry
  int trow, tcol, eff_cols, eff_rows;
  int burst_left, sent;
  bit no_gaps;
  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  wave_equation_stencil_update uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  stencil_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .err_count(err_count), .pending(pending)
  );

  // Stall modes: open, light random, heavy random. Mode is redrawn every so often.
  always @(posedge clk) begin
    if (stall_left <= 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b0;
    endcase
  end

  // generous stop in case the block hangs
  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly smooth fields so the stencil math stays in range; some full-range
  // words and corner values to push saturation and toggle every bit.
  function automatic logic [31:0] pick_field();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return $urandom;
    if (sel == 2) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'hffffffff;
        default: return 32'h0;
      endcase
    end
    return 32'($urandom_range(0, 2 ** 21) - 2 ** 20);
  endfunction

  function automatic in_item_t make_point();
    in_item_t it;
    it.field_now = pick_field();
    it.speed_sq = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom_range(0, 65535));
    it.field_old = pick_field();
    it.inject = ($urandom_range(0, 4) == 0) ? pick_field() : 32'h0;
    return it;
  endfunction

  // Write all four registers back to back, then drop the write enable.
  task automatic write_regs(int cols, int rows, int cx, int cy);
    cfg_we <= 1'b1;
    cfg_addr <= REG_GRID_COLS;
    cfg_wdata <= 24'(cols);
    @(posedge clk);
    cfg_addr <= REG_GRID_ROWS;
    cfg_wdata <= 24'(rows);
    @(posedge clk);
    cfg_addr <= REG_COEF_X;
    cfg_wdata <= 24'(cx);
    @(posedge clk);
    cfg_addr <= REG_COEF_Y;
    cfg_wdata <= 24'(cy);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    eff_cols = (cols < 3) ? 3 : ((cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols);
    eff_rows = (rows < 3) ? 3 : rows;
  endtask

  // One request through the handshake; valid stays up for back to back requests.
  task automatic send_point(in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (tcol >= eff_cols - 1) begin
      tcol = 0;
      trow = (trow >= eff_rows - 1) ? 0 : trow + 1;
    end else begin
      tcol++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic run_points(int n);
    for (int i = 0; i < n; i++) send_point(make_point());
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the pipe has drained; the extra cycles cover
  // border points still inside the block.
  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    int nc, nr;
    trow = 0;
    tcol = 0;
    sent = 0;
    burst_left = 1;
    no_gaps = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 frames, one interior point each. Cols 2 and rows 0 clamp to 3.
    // First frame drives the sum to positive saturation.
    write_regs(2, 0, 24'hffffff, 24'hffffff);
    for (int i = 0; i < 9; i++) begin
      it.field_now = 32'h7fffffff;
      it.speed_sq = 16'hffff;
      it.field_old = 32'h80000000;
      it.inject = 32'h7fffffff;
      send_point(it);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    // negative saturation: magnitude of the most negative value saturates
    write_regs(3, 3, 0, 24'hffffff);
    for (int i = 0; i < 9; i++) begin
      it.field_now = 32'h80000000;
      it.speed_sq = 16'h0;
      it.field_old = 32'h7fffffff;
      it.inject = 32'h80000000;
      send_point(it);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    // checkerboard with zero coefficients and alternating speeds
    write_regs(1, 2, 0, 0);
    for (int i = 0; i < 9; i++) begin
      it.field_now = (i % 2) ? 32'hffff0000 : 32'h00010000;
      it.speed_sq = (i % 2) ? 16'hffff : 16'h0;
      it.field_old = (i % 3) ? 32'h0 : 32'hffffffff;
      it.inject = (i == 8) ? 32'h00008000 : 32'h0;
      send_point(it);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();

    // Random phases of small grids; each phase runs whole frames.
    while (sent < 1650) begin
      nc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      nr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: write_regs(nc, nr, 0, $urandom_range(0, 24'hffffff));
        1: write_regs(nc, nr, 24'hffffff, 24'hffffff);
        default: write_regs(nc, nr, $urandom_range(0, 24'hffffff),
                            $urandom_range(0, 24'hffffff));
      endcase
      nc = eff_cols;
      nr = eff_rows;
      run_points(nc * nr * $urandom_range(1, 3));
      wait_drained();
    end

    // Tallest frame: four full rows, then shrink the row count so the row
    // counter wraps back to a frame start.
    no_gaps = 0;
    write_regs(16, 65535, $urandom_range(0, 24'hffffff), $urandom_range(0, 24'hffffff));
    run_points(4 * 16);
    wait_drained();
    write_regs(16, 3, $urandom_range(0, 24'hffffff), $urandom_range(0, 24'hffffff));
    while (!(trow == 0 && tcol == 0)) send_point(make_point());
    in_valid <= 1'b0;
    @(posedge clk);
    run_points(3 * 16);
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
